### rtl/core/fdps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_pkg
// Shared types, constants and fixed-point helpers for the film development
// pixel step core. All values are unsigned Q8.16 with Q24.16 intermediates.
// ----------------------------------------------------------------------------
package fdps_pkg;

    localparam int VAL_W   = 24;
    localparam int WIDE_W  = 40;
    localparam int FRAC_W  = 16;
    localparam int NSTAGES = 8;
    localparam int IDX_W   = 2;

    localparam logic [VAL_W-1:0]  MAX24 = {VAL_W{1'b1}};
    localparam logic [WIDE_W-1:0] CAP40 = {WIDE_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_GROWTH_GAIN    = 2'd0,
        REG_DEVELOPER_GAIN = 2'd1,
        REG_SALT_GAIN      = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [VAL_W-1:0] developer_in;
        logic [VAL_W-1:0] salt_red;
        logic [VAL_W-1:0] salt_green;
        logic [VAL_W-1:0] salt_blue;
        logic [VAL_W-1:0] radius_red;
        logic [VAL_W-1:0] radius_green;
        logic [VAL_W-1:0] radius_blue;
        logic [VAL_W-1:0] active_red;
        logic [VAL_W-1:0] active_green;
        logic [VAL_W-1:0] active_blue;
    } pixel_t;

    typedef struct packed {
        logic [VAL_W-1:0] developer_out;
        logic [VAL_W-1:0] new_radius_red;
        logic [VAL_W-1:0] new_radius_green;
        logic [VAL_W-1:0] new_radius_blue;
        logic [VAL_W-1:0] new_salt_red;
        logic [VAL_W-1:0] new_salt_green;
        logic [VAL_W-1:0] new_salt_blue;
    } result_t;

    typedef struct packed {
        logic [VAL_W-1:0] growth_gain;
        logic [VAL_W-1:0] developer_gain;
        logic [VAL_W-1:0] salt_gain;
    } cfg_t;

    // One load enable per pipeline register stage; bit 0 is the first stage.
    typedef struct packed {
        logic [NSTAGES-1:0] load;
    } ctrl_t;

    // Full product, drop the fraction bits, saturate to the Q24.16 range.
    function automatic logic [WIDE_W-1:0] qmul(input logic [WIDE_W-1:0] wide,
                                               input logic [VAL_W-1:0] narrow);
        logic [WIDE_W+VAL_W-1:0]        prod;
        logic [WIDE_W+VAL_W-FRAC_W-1:0] shifted;
        prod    = {{VAL_W{1'b0}}, wide} * {{WIDE_W{1'b0}}, narrow};
        shifted = prod[WIDE_W+VAL_W-1:FRAC_W];
        if (|shifted[WIDE_W+VAL_W-FRAC_W-1:WIDE_W])
            return CAP40;
        return shifted[WIDE_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] sub_clamp(input logic [VAL_W-1:0] a,
                                                   input logic [WIDE_W-1:0] b);
        logic [WIDE_W-1:0] a_wide;
        logic [WIDE_W-1:0] diff;
        a_wide = {{(WIDE_W-VAL_W){1'b0}}, a};
        diff   = a_wide - b;
        if (a_wide > b)
            return diff[VAL_W-1:0];
        return '0;
    endfunction

    function automatic logic [VAL_W-1:0] add_sat24(input logic [VAL_W-1:0] a,
                                                   input logic [WIDE_W-1:0] b);
        logic [WIDE_W:0] sum;
        sum = {{(WIDE_W-VAL_W+1){1'b0}}, a} + {1'b0, b};
        if (|sum[WIDE_W:VAL_W])
            return MAX24;
        return sum[VAL_W-1:0];
    endfunction

    // All terms are non-negative, so one cap on the full sum equals capping
    // after every addition.
    function automatic logic [WIDE_W-1:0] sum3_sat(input logic [WIDE_W-1:0] a,
                                                   input logic [WIDE_W-1:0] b,
                                                   input logic [WIDE_W-1:0] c);
        logic [WIDE_W+1:0] sum;
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (|sum[WIDE_W+1:WIDE_W])
            return CAP40;
        return sum[WIDE_W-1:0];
    endfunction

endpackage

### rtl/core/fdps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_cfg_regs
// Gain register file written through a plain write port. Writes to an
// unknown index are dropped.
// ----------------------------------------------------------------------------
module fdps_cfg_regs
    import fdps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [VAL_W-1:0] wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_GROWTH_GAIN:    cfg_next.growth_gain    = wr_data;
                REG_DEVELOPER_GAIN: cfg_next.developer_gain = wr_data;
                REG_SALT_GAIN:      cfg_next.salt_gain      = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/fdps_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_pipe_ctrl
// Valid bits and load enables for the pipeline. A stage loads when it is
// empty or the stage after it loads, so bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module fdps_pipe_ctrl
    import fdps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  pixel_valid,
    output logic  pixel_stall,
    output logic  result_valid,
    input  logic  result_stall,
    output ctrl_t ctrl
);

    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;
    logic [NSTAGES-1:0] ready;
    logic [NSTAGES-1:0] src_valid;

    always_comb
    begin
        ready[NSTAGES-1] = !valid_reg[NSTAGES-1] || !result_stall;
        for (int i = NSTAGES - 2; i >= 0; i--)
            ready[i] = !valid_reg[i] || ready[i+1];
    end

    assign src_valid = {valid_reg[NSTAGES-2:0], pixel_valid};

    always_comb
    begin
        for (int i = 0; i < NSTAGES; i++)
            valid_next[i] = ready[i] ? src_valid[i] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign ctrl.load    = ready & src_valid;
    assign pixel_stall  = !ready[0];
    assign result_valid = valid_reg[NSTAGES-1];

`ifndef SYNTH
    // The input side is held off only when every stage holds a transaction.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (&valid_reg))
        else $error("input stalled while the pipeline has a free stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> valid_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTAGES-1] && !result_stall && !valid_reg[NSTAGES-2])
        |=> !valid_reg[NSTAGES-1])
        else $error("delivered result left valid in the output stage");
`endif

endmodule

### rtl/core/fdps_layer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_layer
// Multiply chain for one colour layer: radius gain, deposited volume, new
// radius and new salt density, at most one multiply per stage.
// ----------------------------------------------------------------------------
module fdps_layer
    import fdps_pkg::*;
(
    input  logic              clk,
    input  ctrl_t             ctrl,
    input  cfg_t              cfg,
    input  logic [VAL_W-1:0]  developer,
    input  logic [VAL_W-1:0]  salt,
    input  logic [VAL_W-1:0]  radius,
    input  logic [VAL_W-1:0]  active,
    output logic [WIDE_W-1:0] volume,
    output logic [VAL_W-1:0]  new_radius,
    output logic [VAL_W-1:0]  new_salt
);

    // Stage 1: developer times salt.
    logic [WIDE_W-1:0] ds_reg, ds_next;
    logic [VAL_W-1:0]  salt1_reg, rad1_reg, act1_reg;
    // Stage 2: radius gain.
    logic [WIDE_W-1:0] dr_reg, dr_next;
    logic [VAL_W-1:0]  salt2_reg, rad2_reg, act2_reg;
    // Stage 3: first radius factor and new radius.
    logic [WIDE_W-1:0] v1_reg, v1_next;
    logic [VAL_W-1:0]  nr3_reg, nr3_next;
    logic [VAL_W-1:0]  salt3_reg, rad3_reg, act3_reg;
    // Stage 4: second radius factor.
    logic [WIDE_W-1:0] v2_reg, v2_next;
    logic [VAL_W-1:0]  nr4_reg, salt4_reg, act4_reg;
    // Stage 5: volume.
    logic [WIDE_W-1:0] vol_reg, vol_next;
    logic [VAL_W-1:0]  nr5_reg, salt5_reg;
    // Stage 6: salt consumption.
    logic [WIDE_W-1:0] cs_reg, cs_next;
    logic [VAL_W-1:0]  nr6_reg, salt6_reg;
    // Stage 7: new salt.
    logic [VAL_W-1:0]  ns7_reg, ns7_next, nr7_reg;
    // Stage 8: output register.
    logic [VAL_W-1:0]  ns8_reg, nr8_reg;

    always_comb
    begin
        ds_next  = qmul({{(WIDE_W-VAL_W){1'b0}}, developer}, salt);
        dr_next  = qmul(ds_reg, cfg.growth_gain);
        v1_next  = qmul(dr_reg, rad2_reg);
        nr3_next = add_sat24(rad2_reg, dr_reg);
        v2_next  = qmul(v1_reg, rad3_reg);
        vol_next = qmul(v2_reg, act4_reg);
        cs_next  = qmul(vol_reg, cfg.salt_gain);
        ns7_next = sub_clamp(salt6_reg, cs_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            ds_reg    <= ds_next;
            salt1_reg <= salt;
            rad1_reg  <= radius;
            act1_reg  <= active;
        end
        if (ctrl.load[1])
        begin
            dr_reg    <= dr_next;
            salt2_reg <= salt1_reg;
            rad2_reg  <= rad1_reg;
            act2_reg  <= act1_reg;
        end
        if (ctrl.load[2])
        begin
            v1_reg    <= v1_next;
            nr3_reg   <= nr3_next;
            salt3_reg <= salt2_reg;
            rad3_reg  <= rad2_reg;
            act3_reg  <= act2_reg;
        end
        if (ctrl.load[3])
        begin
            v2_reg    <= v2_next;
            nr4_reg   <= nr3_reg;
            salt4_reg <= salt3_reg;
            act4_reg  <= act3_reg;
        end
        if (ctrl.load[4])
        begin
            vol_reg   <= vol_next;
            nr5_reg   <= nr4_reg;
            salt5_reg <= salt4_reg;
        end
        if (ctrl.load[5])
        begin
            cs_reg    <= cs_next;
            nr6_reg   <= nr5_reg;
            salt6_reg <= salt5_reg;
        end
        if (ctrl.load[6])
        begin
            ns7_reg <= ns7_next;
            nr7_reg <= nr6_reg;
        end
        if (ctrl.load[7])
        begin
            ns8_reg <= ns7_reg;
            nr8_reg <= nr7_reg;
        end
    end

    assign volume     = vol_reg;
    assign new_radius = nr8_reg;
    assign new_salt   = ns8_reg;

endmodule

### rtl/core/fdps_dev_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_dev_path
// Developer path: carries the developer value alongside the layers, sums
// the three volumes and subtracts the developer consumption.
// ----------------------------------------------------------------------------
module fdps_dev_path
    import fdps_pkg::*;
(
    input  logic              clk,
    input  ctrl_t             ctrl,
    input  cfg_t              cfg,
    input  logic [VAL_W-1:0]  developer_in,
    input  logic [WIDE_W-1:0] vol_red,
    input  logic [WIDE_W-1:0] vol_green,
    input  logic [WIDE_W-1:0] vol_blue,
    output logic [VAL_W-1:0]  developer_out
);

    // dev_reg[i] belongs to stage i + 1.
    logic [VAL_W-1:0]  dev_reg [NSTAGES-1];
    logic [WIDE_W-1:0] vsum_reg, vsum_next;
    logic [WIDE_W-1:0] used_reg, used_next;
    logic [VAL_W-1:0]  out_reg, out_next;

    always_comb
    begin
        vsum_next = sum3_sat(vol_red, vol_green, vol_blue);
        used_next = qmul(vsum_reg, cfg.developer_gain);
        out_next  = sub_clamp(dev_reg[NSTAGES-2], used_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
            dev_reg[0] <= developer_in;
        for (int i = 1; i < NSTAGES - 1; i++)
        begin
            if (ctrl.load[i])
                dev_reg[i] <= dev_reg[i-1];
        end
        if (ctrl.load[5])
            vsum_reg <= vsum_next;
        if (ctrl.load[6])
            used_reg <= used_next;
        if (ctrl.load[7])
            out_reg <= out_next;
    end

    assign developer_out = out_reg;

endmodule

### rtl/core/film_development_pixel_step_core.sv
`timescale 1ns / 1ps
// An accepted pixel passes through the pipeline stages, at most one multiply per stage.
// Throughput: one pixel per cycle while pixel_stall is low, through the eight-stage pipeline.
// A stalled output holds the last stage; empty stages keep filling behind it.
// Reset clears all valid bits and sets the three gain registers to zero;
// payload registers are not reset.
// ----------------------------------------------------------------------------
// film_development_pixel_step_core
// Per-pixel film development step for three colour layers sharing one
// developer concentration, in unsigned Q8.16 with saturation.
// ----------------------------------------------------------------------------
module film_development_pixel_step_core
    import fdps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [VAL_W-1:0] wr_data,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  pixel_t           pixel,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result
);

    cfg_t              cfg;
    ctrl_t             ctrl;
    logic [WIDE_W-1:0] vol_red, vol_green, vol_blue;

    fdps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    fdps_pipe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctrl         (ctrl)
    );

    fdps_layer u_red (
        .clk        (clk),
        .ctrl       (ctrl),
        .cfg        (cfg),
        .developer  (pixel.developer_in),
        .salt       (pixel.salt_red),
        .radius     (pixel.radius_red),
        .active     (pixel.active_red),
        .volume     (vol_red),
        .new_radius (result.new_radius_red),
        .new_salt   (result.new_salt_red)
    );

    fdps_layer u_green (
        .clk        (clk),
        .ctrl       (ctrl),
        .cfg        (cfg),
        .developer  (pixel.developer_in),
        .salt       (pixel.salt_green),
        .radius     (pixel.radius_green),
        .active     (pixel.active_green),
        .volume     (vol_green),
        .new_radius (result.new_radius_green),
        .new_salt   (result.new_salt_green)
    );

    fdps_layer u_blue (
        .clk        (clk),
        .ctrl       (ctrl),
        .cfg        (cfg),
        .developer  (pixel.developer_in),
        .salt       (pixel.salt_blue),
        .radius     (pixel.radius_blue),
        .active     (pixel.active_blue),
        .volume     (vol_blue),
        .new_radius (result.new_radius_blue),
        .new_salt   (result.new_salt_blue)
    );

    fdps_dev_path u_dev (
        .clk           (clk),
        .ctrl          (ctrl),
        .cfg           (cfg),
        .developer_in  (pixel.developer_in),
        .vol_red       (vol_red),
        .vol_green     (vol_green),
        .vol_blue      (vol_blue),
        .developer_out (result.developer_out)
    );

endmodule
